### src/next_fit_slot_allocator_core_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef NEXT_FIT_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define NEXT_FIT_SLOT_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define NFSA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define NFSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/nfsa_pkg.sv
package nfsa_pkg;

  localparam int unsigned POOL_SIZE = 1024;
  localparam int unsigned IDX_W     = $clog2(POOL_SIZE);
  localparam int unsigned CNT_W     = IDX_W + 1;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BIT_W     = $clog2(WORD_W);
  localparam int unsigned NUM_WORDS = POOL_SIZE / WORD_W;
  localparam int unsigned WADDR_W   = $clog2(NUM_WORDS);

  localparam logic [CNT_W-1:0] POOL_FULL = CNT_W'(POOL_SIZE);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOT_USED = 2'd3
  } status_e;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] granted_index;
    logic [CNT_W-1:0] used_count;
  } res_t;

  // Bits below position b are set.
  function automatic logic [WORD_W-1:0] lt_mask(input logic [BIT_W-1:0] b);
    logic [WORD_W-1:0] m;
    for (int j = 0; j < WORD_W; j++) begin
      m[j] = (BIT_W'(j) < b);
    end
    return m;
  endfunction

  // Position of the lowest set bit; zero when the word is empty.
  function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] p;
    p = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (w[j]) begin
        p = BIT_W'(j);
      end
    end
    return p;
  endfunction

endpackage

### src/next_fit_slot_allocator_core.sv
// A free reads its bitmap word in S_RD and checks and clears the slot in S_EV; a rejected
// free, or an allocate on an empty pool, is answered from S_IDLE without a RAM read.
// An allocate passes through S_RD then S_EV for each of the W 32-slot bitmap words
// it visits (1 to 33), each read from RAM and evaluated by the one scan unit.
// One request at a time: busy stays high until the result strobe is issued, and
// done_o pulses for one cycle. Reset (async, active low) clears all slot flags at once.
`include "next_fit_slot_allocator_core_macros.svh"

module next_fit_slot_allocator_core
  import nfsa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  output logic             done_o,
  output res_t             res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EV   = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [CNT_W-1:0]     pool_q, pool_d;
  logic [IDX_W-1:0]     cursor_q, cursor_d;
  logic [CNT_W-1:0]     used_q, used_d;
  logic [NUM_WORDS-1:0] row_vld_q, row_vld_d;
  logic                 op_q, op_d;
  logic [WADDR_W-1:0]   addr_q, addr_d;
  logic [BIT_W-1:0]     bit_q, bit_d;
  logic                 wrapped_q, wrapped_d;
  logic                 done_q, done_d;
  res_t                 res_q, res_d;

  logic [CNT_W-1:0]     n_eff;
  logic [CNT_W-1:0]     n_m1;
  logic [WADDR_W-1:0]   last_word;
  logic [WADDR_W-1:0]   cur_word;
  logic [WORD_W-1:0]    rd_data;
  logic [WORD_W-1:0]    word;
  logic [WORD_W-1:0]    hi_mask;
  logic [WORD_W-1:0]    lt_cur;
  logic [WORD_W-1:0]    cand;
  logic                 found;
  logic [BIT_W-1:0]     pos;
  logic [IDX_W-1:0]     got_idx;
  logic [CNT_W-1:0]     got_next;
  logic [WORD_W-1:0]    onehot;
  logic                 ram_we;
  logic [WORD_W-1:0]    ram_wdata;
  logic                 accept;

  assign accept      = start && (state_q == S_IDLE);
  assign busy        = (state_q != S_IDLE);
  // A pool size write never lands in the same cycle as a new request.
  assign cfg_ready_o = (state_q == S_IDLE) && !start;
  assign done_o      = done_q;
  assign res_o       = res_q;

  // Active slot count saturates at the pool size.
  assign n_eff     = (pool_q > POOL_FULL) ? POOL_FULL : pool_q;
  assign n_m1      = n_eff - CNT_W'(1);
  assign last_word = n_m1[IDX_W-1:BIT_W];
  assign cur_word  = cursor_q[IDX_W-1:BIT_W];

  nfsa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  // A row never written since reset reads as all free.
  assign word   = row_vld_q[addr_q] ? rd_data : '0;
  assign onehot = WORD_W'(1) << bit_q;

  // Scan unit: free slots of the current word inside the active pool and on
  // the proper side of the cursor for this pass.
  always_comb begin
    if ({1'b0, addr_q} < n_eff[CNT_W-1:BIT_W]) begin
      hi_mask = '1;
    end else if ({1'b0, addr_q} == n_eff[CNT_W-1:BIT_W]) begin
      hi_mask = lt_mask(n_eff[BIT_W-1:0]);
    end else begin
      hi_mask = '0;
    end
    if (addr_q < cur_word) begin
      lt_cur = '1;
    end else if (addr_q == cur_word) begin
      lt_cur = lt_mask(cursor_q[BIT_W-1:0]);
    end else begin
      lt_cur = '0;
    end
    cand     = ~word & hi_mask & (wrapped_q ? lt_cur : ~lt_cur);
    found    = |cand;
    pos      = first_set(cand);
    got_idx  = {addr_q, pos};
    got_next = {1'b0, got_idx} + CNT_W'(1);
  end

  always_comb begin
    state_d   = state_q;
    pool_d    = pool_q;
    cursor_d  = cursor_q;
    used_d    = used_q;
    row_vld_d = row_vld_q;
    op_d      = op_q;
    addr_d    = addr_q;
    bit_d     = bit_q;
    wrapped_d = wrapped_q;
    done_d    = 1'b0;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_wdata = word;

    case (state_q)
      S_IDLE: begin
        if (cfg_valid_i && cfg_ready_o) begin
          pool_d = cfg_data_i;
        end
        if (accept) begin
          op_d                = req_i.req_type;
          wrapped_d           = 1'b0;
          res_d.granted_index = '0;
          res_d.used_count    = used_q;
          if (req_i.req_type == REQ_ALLOC) begin
            if (n_eff == '0) begin
              res_d.status = ST_FULL;
              done_d       = 1'b1;
            end else if ({1'b0, cursor_q} >= n_m1) begin
              cursor_d = '0;
              addr_d   = '0;
              state_d  = S_RD;
            end else begin
              addr_d  = cur_word;
              state_d = S_RD;
            end
          end else begin
            if ({1'b0, req_i.slot_index} >= n_eff) begin
              res_d.status = ST_RANGE;
              done_d       = 1'b1;
            end else begin
              addr_d  = req_i.slot_index[IDX_W-1:BIT_W];
              bit_d   = req_i.slot_index[BIT_W-1:0];
              state_d = S_RD;
            end
          end
        end
      end

      S_RD: begin
        state_d = S_EV;
      end

      S_EV: begin
        if (op_q == REQ_ALLOC) begin
          if (found) begin
            ram_we              = 1'b1;
            ram_wdata           = word | (WORD_W'(1) << pos);
            row_vld_d[addr_q]   = 1'b1;
            used_d              = used_q + CNT_W'(1);
            cursor_d            = (got_next >= n_eff) ? '0 : got_next[IDX_W-1:0];
            res_d.status        = ST_OK;
            res_d.granted_index = got_idx;
            res_d.used_count    = used_q + CNT_W'(1);
            done_d              = 1'b1;
            state_d             = S_IDLE;
          end else if (!wrapped_q && (addr_q == last_word)) begin
            // End of the active pool: continue from slot zero up to the cursor.
            wrapped_d = 1'b1;
            addr_d    = '0;
            state_d   = S_RD;
          end else if (wrapped_q && (addr_q == cur_word)) begin
            res_d.status = ST_FULL;
            done_d       = 1'b1;
            state_d      = S_IDLE;
          end else begin
            addr_d  = addr_q + WADDR_W'(1);
            state_d = S_RD;
          end
        end else begin
          if (word[bit_q]) begin
            ram_we            = 1'b1;
            ram_wdata         = word & ~onehot;
            row_vld_d[addr_q] = 1'b1;
            used_d            = (used_q != '0) ? used_q - CNT_W'(1) : used_q;
            res_d.status      = ST_OK;
            res_d.used_count  = used_d;
          end else begin
            res_d.status = ST_NOT_USED;
          end
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pool_q    <= POOL_FULL;
      cursor_q  <= '0;
      used_q    <= '0;
      row_vld_q <= '0;
      op_q      <= REQ_ALLOC;
      addr_q    <= '0;
      bit_q     <= '0;
      wrapped_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      pool_q    <= pool_d;
      cursor_q  <= cursor_d;
      used_q    <= used_d;
      row_vld_q <= row_vld_d;
      op_q      <= op_d;
      addr_q    <= addr_d;
      bit_q     <= bit_d;
      wrapped_q <= wrapped_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  `NFSA_ASSERT_SAME(a_done_idle, done_q, !busy, "result issued while still busy")
  `NFSA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_q,
                    "accepted request neither started nor answered")
  `NFSA_ASSERT_SAME(a_count_bound, 1'b1, used_q <= POOL_FULL,
                    "used count exceeds pool size")
  `NFSA_ASSERT_SAME(a_grant_ok, done_q && (res_q.granted_index != '0),
                    res_q.status == ST_OK, "nonzero grant without ok status")

endmodule

### src/nfsa_ram.sv
module nfsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### test/slot_alloc_monitor.sv
`timescale 1ns / 100ps

module slot_alloc_monitor
  import nfsa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  req_t             req_i,
  input  logic             done_o,
  input  res_t             res_o,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i,
  output int unsigned      mismatch_count,
  output int unsigned      replies_due
);

  logic [POOL_SIZE-1:0] shadow_used;
  int unsigned          shadow_cursor;
  int unsigned          shadow_total;
  logic [CNT_W-1:0]     shadow_pool;
  res_t                 pending_replies[$];
  int unsigned          fail_count;
  res_t                 want;

  assign mismatch_count = fail_count;

  // Applies one request to the shadow allocator and returns the reply it should give.
  function automatic res_t serve_request(input req_t rq);
    int unsigned live;
    int unsigned pick;
    logic        found;
    res_t        rs;
    live  = (shadow_pool > POOL_SIZE) ? POOL_SIZE : shadow_pool;
    found = 1'b0;
    pick  = 0;
    rs.status        = ST_OK;
    rs.granted_index = '0;
    if (rq.req_type == REQ_ALLOC) begin
      if (live != 0) begin
        if (shadow_cursor >= live - 1) begin
          shadow_cursor = 0;
        end
        for (int unsigned i = shadow_cursor; i < live && !found; i++) begin
          if (!shadow_used[i]) begin
            found = 1'b1;
            pick  = i;
          end
        end
        // The wrapped scan covers every slot below the cursor.
        for (int unsigned i = 0; i < shadow_cursor && i < live && !found; i++) begin
          if (!shadow_used[i]) begin
            found = 1'b1;
            pick  = i;
          end
        end
      end
      if (found) begin
        shadow_used[pick] = 1'b1;
        shadow_total++;
        shadow_cursor = (pick + 1 > live - 1) ? 0 : pick + 1;
        rs.granted_index = IDX_W'(pick);
      end else begin
        rs.status = ST_FULL;
      end
    end else if (rq.slot_index >= live) begin
      rs.status = ST_RANGE;
    end else if (!shadow_used[rq.slot_index]) begin
      rs.status = ST_NOT_USED;
    end else begin
      shadow_used[rq.slot_index] = 1'b0;
      if (shadow_total > 0) begin
        shadow_total--;
      end
    end
    rs.used_count = CNT_W'(shadow_total);
    return rs;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_used   = '0;
      shadow_cursor = 0;
      shadow_total  = 0;
      shadow_pool   = POOL_FULL;
      pending_replies.delete();
      fail_count    = 0;
      replies_due  <= 0;
    end else begin
      if (done_o) begin
        if (pending_replies.size() == 0) begin
          $error("result with no request outstanding: status %0d index %0d count %0d",
                 res_o.status, res_o.granted_index, res_o.used_count);
          fail_count++;
        end else begin
          want = pending_replies.pop_front();
          if (res_o.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_o.status);
            fail_count++;
          end
          if (res_o.granted_index !== want.granted_index) begin
            $error("granted_index: expected %0d, actual %0d",
                   want.granted_index, res_o.granted_index);
            fail_count++;
          end
          if (res_o.used_count !== want.used_count) begin
            $error("used_count: expected %0d, actual %0d", want.used_count, res_o.used_count);
            fail_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        shadow_pool = cfg_data_i;
      end
      if (start && !busy) begin
        pending_replies.push_back(serve_request(req_i));
      end
      replies_due <= pending_replies.size();
    end
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import nfsa_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  req_t             req_i;
  logic             done_o;
  res_t             res_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i;

  int unsigned fail_total;
  int unsigned in_flight;
  int unsigned pool_now;
  logic        no_gaps;

  next_fit_slot_allocator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  slot_alloc_monitor u_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .done_o         (done_o),
    .res_o          (res_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .mismatch_count (fail_total),
    .replies_due    (in_flight)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 40);
  endfunction

  // Frees mostly target slots that can be in use, sometimes anything at all.
  function automatic logic [IDX_W-1:0] pick_victim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15 || pool_now == 0) begin
      return IDX_W'($urandom_range(0, POOL_SIZE - 1));
    end
    if (pool_now > 96 && r < 60) begin
      return IDX_W'($urandom_range(0, 95));
    end
    return IDX_W'($urandom_range(0, pool_now - 1));
  endfunction

  task automatic send(input logic kind, input logic [IDX_W-1:0] idx);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{req_type: kind, slot_index: idx};
    do @(posedge clk_i); while (busy);
  endtask

  task automatic alloc_slot();
    send(REQ_ALLOC, IDX_W'($urandom_range(0, POOL_SIZE - 1)));
  endtask

  // The pool size only changes once every outstanding request has answered.
  task automatic write_pool(input logic [CNT_W-1:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
    repeat (4 + pick_gap()) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pool_now = (value > POOL_SIZE) ? POOL_SIZE : value;
  endtask

  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned issued;
    int unsigned sel;
    int unsigned size;
    int unsigned span;
    int unsigned alloc_pct;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    pool_now    = POOL_SIZE;
    no_gaps     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset pool.
    send(REQ_FREE, '0);
    alloc_slot();
    alloc_slot();
    send(REQ_FREE, '1);
    send(REQ_FREE, IDX_W'(1));
    send(REQ_FREE, IDX_W'(1));

    // Two slots: fill it, then free past the end.
    write_pool(CNT_W'(2));
    alloc_slot();
    alloc_slot();
    alloc_slot();
    send(REQ_FREE, IDX_W'(2));
    send(REQ_FREE, '1);

    // An empty pool rejects everything.
    write_pool('0);
    alloc_slot();
    send(REQ_FREE, '0);

    // A single slot.
    write_pool(CNT_W'(1));
    alloc_slot();
    send(REQ_FREE, '0);
    alloc_slot();
    alloc_slot();

    // Oversized setting saturates at the full pool.
    write_pool('1);
    alloc_slot();
    alloc_slot();
    send(REQ_FREE, '1);
    send(REQ_FREE, IDX_W'(1));
    alloc_slot();

    issued = 0;
    while (issued < 1230) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        size = $urandom_range(2, 70);
      end else if (sel < 62) begin
        size = POOL_SIZE;
      end else if (sel < 72) begin
        size = $urandom_range(71, POOL_SIZE - 1);
      end else if (sel < 80) begin
        size = $urandom_range(0, 1);
      end else if (sel < 88) begin
        size = $urandom_range(POOL_SIZE + 1, 2047);
      end else begin
        size = 2;
      end
      write_pool(CNT_W'(size));
      case ($urandom_range(0, 3))
        0: alloc_pct = 20;
        1: alloc_pct = 50;
        2: alloc_pct = 75;
        default: alloc_pct = 95;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      span = $urandom_range(20, 90);
      repeat (span) begin
        if ($urandom_range(0, 99) < alloc_pct) begin
          alloc_slot();
        end else begin
          send(REQ_FREE, pick_victim());
        end
      end
      no_gaps = 1'b0;
      issued += span;
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_total == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/nfsa_pkg.sv
src/nfsa_ram.sv
src/next_fit_slot_allocator_core.sv
test/slot_alloc_monitor.sv
test/testbench.sv
